[rtl/uule_pkg.sv]
// ----------------------------------------------------------------------------
// uule_pkg
// Shared constants, types and helpers for the uuencode line encoder.
// ----------------------------------------------------------------------------
package uule_pkg;

    // bytes in one full line
    localparam int LINE_BYTES = 45;
    // width of a byte count within a line, able to hold LINE_BYTES itself
    localparam int CNT_W      = $clog2(LINE_BYTES + 1);
    // two line banks, one filling while the other drains
    localparam int NUM_BANKS  = 2;
    localparam int MEM_DEPTH  = NUM_BANKS * LINE_BYTES;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);

    // character codes
    localparam logic [6:0] CHAR_BASE    = 7'h20;
    localparam logic [6:0] CHAR_NEWLINE = 7'd10;

    // one closed line waiting to be encoded
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
    } line_job_t;

    // line buffer write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

    // line buffer read request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } mem_rd_t;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_C0,
        ST_C1,
        ST_C2,
        ST_C3,
        ST_NL
    } back_state_t;

    // address of byte idx in a bank
    function automatic logic [ADDR_W-1:0] line_addr(input logic bank,
                                                    input logic [CNT_W-1:0] idx);
        line_addr = ADDR_W'(idx) + (bank ? ADDR_W'(LINE_BYTES) : '0);
    endfunction

    // printable character for a 6-bit sextet
    function automatic logic [6:0] sextet_char(input logic [5:0] s);
        sextet_char = CHAR_BASE + {1'b0, s};
    endfunction

endpackage

[rtl/uule_line_ram.sv]
// ----------------------------------------------------------------------------
// uule_line_ram
// Two-bank line buffer: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module uule_line_ram (
    input  logic              aclk,
    input  uule_pkg::mem_wr_t wr,
    input  uule_pkg::mem_rd_t rd,
    output logic [7:0]        rd_data
);
    import uule_pkg::*;

    logic [7:0] mem [MEM_DEPTH];
    logic [7:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/uule_job_queue.sv]
// ----------------------------------------------------------------------------
// uule_job_queue
// Two-entry queue of closed lines between the byte front end and the encoder.
// ----------------------------------------------------------------------------
module uule_job_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  uule_pkg::line_job_t push_job,
    input  logic                pop,
    output uule_pkg::line_job_t head,
    output logic                empty,
    output logic                full
);
    import uule_pkg::*;

    line_job_t  entry_reg [NUM_BANKS];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] used_reg, used_next;

    // pointer and occupancy update
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        used_next   = used_reg;
        if (push && !pop) begin
            used_next = used_reg + 2'd1;
        end else if (pop && !push) begin
            used_next = used_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            used_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            used_reg   <= used_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (used_reg == 2'd0);
    assign full  = (used_reg == 2'(NUM_BANKS));

endmodule

[rtl/uule_front.sv]
// ----------------------------------------------------------------------------
// uule_front
// Accepts raw bytes, writes them into the filling bank and closes a line
// when it is full or the final byte arrives.
// ----------------------------------------------------------------------------
module uule_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_data_byte,
    input  logic                s_is_final,
    input  logic                q_full,
    output logic                push,
    output uule_pkg::line_job_t push_job,
    output uule_pkg::mem_wr_t   wr
);
    import uule_pkg::*;

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             bank_reg, bank_next;
    logic             beat;
    logic [CNT_W-1:0] count;
    logic             close;

    assign s_ready = !q_full;
    assign beat    = s_valid && s_ready;
    assign count   = fill_reg + CNT_W'(1);
    assign close   = (count == CNT_W'(LINE_BYTES)) || s_is_final;

    // byte write into the filling bank
    always_comb begin
        wr.en   = beat;
        wr.addr = line_addr(bank_reg, fill_reg);
        wr.data = s_data_byte;
    end

    // line close
    always_comb begin
        push           = beat && close;
        push_job.bank  = bank_reg;
        push_job.count = count;
    end

    always_comb begin
        fill_next = fill_reg;
        bank_next = bank_reg;
        if (beat) begin
            if (close) begin
                fill_next = '0;
                bank_next = ~bank_reg;
            end else begin
                fill_next = count;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            bank_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            bank_reg <= bank_next;
        end
    end

endmodule

[rtl/uule_back.sv]
// ----------------------------------------------------------------------------
// uule_back
// Encoder sequencer: reads a closed line byte by byte and emits the length
// character, four characters per group and the closing newline.
// ----------------------------------------------------------------------------
module uule_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  uule_pkg::line_job_t head,
    input  logic                q_empty,
    output logic                pop,
    output uule_pkg::mem_rd_t   rd,
    input  logic [7:0]          rd_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [6:0]          m_out_char,
    output logic                m_run_end
);
    import uule_pkg::*;

    back_state_t      state_reg, state_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [7:0]       a_reg, a_next;
    logic [7:0]       b_reg, b_next;
    logic [7:0]       c_reg, c_next;
    logic             m_valid_reg;
    logic [6:0]       m_char_reg;
    logic             m_end_reg;

    logic             load;
    logic             emit;
    logic [6:0]       emit_char;
    logic             emit_end;
    logic [CNT_W:0]   pos1, pos2, pos3;
    logic             has_b, has_c, has_next;
    logic [7:0]       b_val, c_val;

    // output register free or draining this cycle
    assign load = !m_valid_reg || m_ready;

    // group position checks
    assign pos1     = {1'b0, pos_reg} + (CNT_W+1)'(1);
    assign pos2     = {1'b0, pos_reg} + (CNT_W+1)'(2);
    assign pos3     = {1'b0, pos_reg} + (CNT_W+1)'(3);
    assign has_b    = pos1 < {1'b0, head.count};
    assign has_c    = pos2 < {1'b0, head.count};
    assign has_next = pos3 < {1'b0, head.count};
    assign b_val    = has_b ? rd_data : 8'd0;
    assign c_val    = has_c ? rd_data : 8'd0;

    // next state
    always_comb begin
        state_next = state_reg;
        if (load) begin
            case (state_reg)
                ST_IDLE: if (!q_empty) state_next = ST_C0;
                ST_C0:   state_next = ST_C1;
                ST_C1:   state_next = ST_C2;
                ST_C2:   state_next = ST_C3;
                ST_C3:   state_next = has_next ? ST_C0 : ST_NL;
                ST_NL:   state_next = ST_IDLE;
                default: state_next = ST_IDLE;
            endcase
        end
    end

    // outputs: character, read request, byte latches, queue pop
    always_comb begin
        emit      = 1'b0;
        emit_char = CHAR_NEWLINE;
        emit_end  = 1'b0;
        rd.en     = 1'b0;
        rd.addr   = line_addr(head.bank, pos_reg);
        pop       = 1'b0;
        pos_next  = pos_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    emit      = 1'b1;
                    emit_char = CHAR_BASE + 7'(head.count);
                    rd.en     = load;
                    rd.addr   = line_addr(head.bank, '0);
                    pos_next  = load ? '0 : pos_reg;
                end
            end
            ST_C0: begin
                emit      = 1'b1;
                emit_char = sextet_char(rd_data[7:2]);
                a_next    = load ? rd_data : a_reg;
                rd.en     = load && has_b;
                rd.addr   = line_addr(head.bank, pos1[CNT_W-1:0]);
            end
            ST_C1: begin
                emit      = 1'b1;
                emit_char = sextet_char({a_reg[1:0], b_val[7:4]});
                b_next    = load ? b_val : b_reg;
                rd.en     = load && has_c;
                rd.addr   = line_addr(head.bank, pos2[CNT_W-1:0]);
            end
            ST_C2: begin
                emit      = 1'b1;
                emit_char = sextet_char({b_reg[3:0], c_val[7:6]});
                c_next    = load ? c_val : c_reg;
            end
            ST_C3: begin
                emit      = 1'b1;
                emit_char = sextet_char(c_reg[5:0]);
                rd.en     = load && has_next;
                rd.addr   = line_addr(head.bank, pos3[CNT_W-1:0]);
                if (load && has_next) begin
                    pos_next = pos3[CNT_W-1:0];
                end
            end
            ST_NL: begin
                emit      = 1'b1;
                emit_char = CHAR_NEWLINE;
                emit_end  = 1'b1;
                pop       = load;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // byte latches and group position
    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_char_reg <= emit_char;
            m_end_reg  <= emit_end;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_char = m_char_reg;
    assign m_run_end  = m_end_reg;

endmodule

[rtl/uuencode_line_encoder_unit.sv]
// ----------------------------------------------------------------------------
// uuencode_line_encoder_unit
// Byte-stream uuencode line encoder without begin and end framing lines.
// ----------------------------------------------------------------------------
// Bytes enter one per beat and collect in a two-bank line buffer; a line
// closes at 45 bytes or on a byte marked final. Each closed line comes out
// as a length character, four characters per 3-byte group (a short last
// group padded with zero bytes) and a newline flagged by m_run_end, so a
// line of n bytes gives 2 + 4*ceil(n/3) characters, 62 for a full line.
// The encoder sequencer sends one character per cycle while m_ready is high
// and reads the line through its single buffer read port. The input takes
// one byte per cycle until two closed lines wait to be encoded, then holds
// s_ready low until the older line's newline is loaded into the sequencer's
// output register.
// ----------------------------------------------------------------------------
module uuencode_line_encoder_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_is_final,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_out_char,
    output logic       m_run_end
);
    import uule_pkg::*;

    line_job_t  push_job;
    line_job_t  head;
    logic       push;
    logic       pop;
    logic       q_empty;
    logic       q_full;
    mem_wr_t    wr;
    mem_rd_t    rd;
    logic [7:0] rd_data;

    // byte front end
    uule_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_is_final  (s_is_final),
        .q_full      (q_full),
        .push        (push),
        .push_job    (push_job),
        .wr          (wr)
    );

    // line buffer
    uule_line_ram u_line_ram (
        .aclk    (aclk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    // closed lines waiting for the encoder
    uule_job_queue u_job_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    // encoder sequencer
    uule_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .q_empty    (q_empty),
        .pop        (pop),
        .rd         (rd),
        .rd_data    (rd_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_run_end  (m_run_end)
    );

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for uuencode_line_encoder_unit. Bytes go in with random
// gaps and the character stream is drained with random stalls, except in the
// streaming test. Every accepted byte runs through a local line encoder, which
// queues the characters that the line should produce. Each output beat is
// checked against the head of that queue.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uule_pkg::*;

    // one expected output character
    typedef struct {
        logic [6:0] ch;
        logic       last;
    } enc_char_t;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'h00;
    logic       s_is_final  = 1'b0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [6:0] m_out_char;
    logic       m_run_end;

    // local copy of the line being filled
    logic [7:0] line_buf [LINE_BYTES];
    int         line_fill = 0;

    enc_char_t  expected_chars [$];
    int         errors      = 0;
    bit         src_idle_on = 1'b1;
    bit         sink_idle_on = 1'b1;
    int         sink_hold   = 0;

    uuencode_line_encoder_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_is_final  (s_is_final),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_run_end   (m_run_end)
    );

    always #2 aclk = ~aclk;

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void queue_char(input logic [6:0] ch, input logic last);
        enc_char_t c;
        c.ch   = ch;
        c.last = last;
        expected_chars.push_back(c);
    endfunction

    // line encoder: buffer the byte, emit the whole line when full or final
    function automatic void encode_byte(input logic [7:0] b, input logic fin);
        logic [7:0] a0, a1, a2;
        logic [5:0] sx [4];
        if (line_fill < LINE_BYTES) begin
            line_buf[line_fill] = b;
            line_fill++;
        end
        if (line_fill < LINE_BYTES && !fin) return;
        queue_char(CHAR_BASE + 7'(line_fill), 1'b0);
        for (int i = 0; i < line_fill; i += 3) begin
            // short last group is padded with zero bytes
            a0 = line_buf[i];
            a1 = (i + 1 < line_fill) ? line_buf[i + 1] : 8'h00;
            a2 = (i + 2 < line_fill) ? line_buf[i + 2] : 8'h00;
            sx[0] = a0[7:2];
            sx[1] = {a0[1:0], a1[7:4]};
            sx[2] = {a1[3:0], a2[7:6]};
            sx[3] = a2[5:0];
            for (int k = 0; k < 4; k++) queue_char(CHAR_BASE + {1'b0, sx[k]}, 1'b0);
        end
        queue_char(CHAR_NEWLINE, 1'b1);
        line_fill = 0;
    endfunction

    // send one byte beat, called and returning at a rising edge
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = src_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_is_final  <= fin;
        do @(posedge aclk); while (!s_ready);
        encode_byte(b, fin);
    endtask

    // hold the input until every queued character has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_chars.size() != 0);
    endtask

    task automatic send_line(input int len, input logic fin_last);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)), (i == len - 1) ? fin_last : 1'b0);
    endtask

    // output check and sink stalls
    always @(posedge aclk) begin : out_check
        enc_char_t want;
        int        gap;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected beat: out_char %0h run_end %0b", m_out_char, m_run_end);
                errors++;
            end else begin
                want = expected_chars.pop_front();
                if (m_out_char !== want.ch) begin
                    $error("out_char: expected %0h, got %0h", want.ch, m_out_char);
                    errors++;
                end
                if (m_run_end !== want.last) begin
                    $error("run_end: expected %0b, got %0b", want.last, m_run_end);
                    errors++;
                end
            end
        end
        if (sink_hold > 0) begin
            m_ready <= 1'b0;
            sink_hold--;
        end else begin
            gap = sink_idle_on ? pick_gap() : 0;
            m_ready   <= (gap == 0);
            sink_hold = (gap > 0) ? gap - 1 : 0;
        end
    end

    // extreme bytes and every length of the last group
    task automatic test_short_groups();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h96, 1'b0);
        send_byte(8'h69, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(8'h9A, 1'b1);
        wait_drained();
    endtask

    // no idling on either side: a full line closing by itself, a full line
    // with the final flag, then a short line that stalls while both banks wait
    task automatic test_streaming();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        send_line(LINE_BYTES, 1'b0);
        send_line(LINE_BYTES, 1'b1);
        send_line(2, 1'b1);
        wait_drained();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // random short lines, each closed by the final flag
    task automatic test_random_lines();
        int  sent;
        int  len;
        bit  paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < 12) begin
            len = $urandom_range(1, 6);
            send_line(len, 1'b1);
            sent += len;
            if (!paused && sent >= 6) begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_short_groups();
        test_streaming();
        test_random_lines();
        wait_drained();
        repeat (64) @(posedge aclk);
        if (errors == 0 && expected_chars.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
